>>> hw/rtl/arpc_pkg.sv
// Shared types, constants and codes for the direct-mapped ARP cache.
// Used by arpc_ctrl, arpc_dp and direct_mapped_arp_cache; no dependencies.
`default_nettype none

package arpc_pkg;

  // Cache geometry
  localparam int CACHE_ENTRIES = 128;
  localparam int IDX_W         = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam bit IDX_IS_POW2   = ((1 << IDX_W) == CACHE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

  // Field widths
  localparam int FUNC_W  = 2;
  localparam int IP_W    = 32;
  localparam int MAC_W   = 48;
  localparam int TICK_W  = 32;
  localparam int ENTRY_W = 1 + IP_W + MAC_W;

  // Index remainder by reciprocal: quotient estimate is floor(ip * REM_MUL >> REM_SHIFT),
  // at most one below the true quotient
  localparam int REM_SHIFT = IP_W + IDX_W;
  localparam logic [IP_W:0]   REM_MUL = (IP_W + 1)'(((2 * IP_W + 1)'(1) << REM_SHIFT) /
                                                    CACHE_ENTRIES);
  localparam logic [IP_W-1:0] REM_DIV = IP_W'(CACHE_ENTRIES);

  // Request function codes
  localparam logic [FUNC_W-1:0] FUNC_ADD     = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RESOLVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_GW_MAC    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY     = 1'd1;

  // Register reset values
  localparam logic [MAC_W-1:0]  GW_MAC_RESET = 48'h021A_C54B_7E90;
  localparam logic [TICK_W-1:0] RETRY_RESET  = 32'd5000;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the incoming request
    logic rem_step;  // one step of the index remainder
    logic clr_step;  // clear one entry's valid bit
    logic mem_wr;    // write the add request into its entry
    logic mem_rd;    // read the entry for a resolve
    logic tick;      // advance the elapsed counter
    logic resolve;   // form the result and load the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              clr_last;
    logic              rem_last;
    logic              out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/arpc_ctrl.sv
// Controller state machine for the ARP cache: clearing sweep, request
// sequencing and result hand-off. Depends on arpc_pkg.
`default_nettype none

module arpc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire arpc_pkg::sts_t sts,
  output arpc_pkg::cmd_t     cmd
);

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_INDEX   = 3'd2;
  localparam logic [2:0] S_EXEC    = 3'd3;
  localparam logic [2:0] S_RESOLVE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = arpc_pkg::IDX_IS_POW2 ? S_EXEC : S_INDEX;
        end
      end
      S_INDEX: begin
        cmd.rem_step = 1'b1;
        if (sts.rem_last) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts.func)
          arpc_pkg::FUNC_ADD: begin
            cmd.mem_wr = 1'b1;
            state_next = S_IDLE;
          end
          arpc_pkg::FUNC_RESOLVE: begin
            cmd.mem_rd = 1'b1;
            state_next = S_RESOLVE;
          end
          arpc_pkg::FUNC_TICK: begin
            cmd.tick   = 1'b1;
            state_next = S_IDLE;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_RESOLVE: begin
        // hold the read entry until the output register frees up
        if (sts.out_free) begin
          cmd.resolve = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // One request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in flight");

  // No request taken before the clearing sweep finishes
  a_no_req_in_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_step |-> !cmd.capture && !cmd.mem_wr && !cmd.mem_rd)
    else $error("request activity during clearing sweep");

  // A pending result waits while the output register is busy
  a_resolve_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESOLVE && !sts.out_free) |=> (state == S_RESOLVE))
    else $error("resolve left before its result was loaded");

endmodule

`default_nettype wire

>>> hw/rtl/arpc_dp.sv
// Datapath for the ARP cache: request latch, index remainder, entry memory,
// elapsed counter, config registers and output register. Depends on arpc_pkg.
`default_nettype none

module arpc_dp (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire arpc_pkg::cmd_t                  cmd,
  output arpc_pkg::sts_t                       sts,
  input  wire logic                            cfg_wr_en,
  input  wire logic [arpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [arpc_pkg::MAC_W-1:0]      cfg_wdata,
  input  wire logic [arpc_pkg::FUNC_W-1:0]     func,
  input  wire logic [arpc_pkg::IP_W-1:0]       ip_addr,
  input  wire logic [arpc_pkg::MAC_W-1:0]      mac_in,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 hit,
  output logic [arpc_pkg::MAC_W-1:0]           hop_mac,
  output logic                                 send_arp
);

  localparam int IDX_W = arpc_pkg::IDX_W;

  // Request latch
  logic [arpc_pkg::FUNC_W-1:0] func_q;
  logic [arpc_pkg::IP_W-1:0]   ip_q;
  logic [arpc_pkg::MAC_W-1:0]  mac_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q <= func;
      ip_q   <= ip_addr;
      mac_q  <= mac_in;
    end
  end

  // Index remainder: reciprocal multiply in the first step, one correction in the second
  logic [2*arpc_pkg::IP_W:0]   rem_prod;
  logic [arpc_pkg::IP_W-1:0]   rem_quot;
  logic [arpc_pkg::IP_W-1:0]   rem_diff;
  logic [IDX_W-1:0]            rem;
  logic                        rem_phase;

  assign rem_prod = ip_q * arpc_pkg::REM_MUL;
  assign rem_diff = ip_q - (rem_quot * arpc_pkg::REM_DIV);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rem_phase <= 1'b0;
    end else if (cmd.rem_step) begin
      if (!rem_phase) begin
        rem_quot <= arpc_pkg::IP_W'(rem_prod >> arpc_pkg::REM_SHIFT);
      end else begin
        // estimate is at most one low, so one subtract finishes the remainder
        rem <= (rem_diff >= arpc_pkg::REM_DIV) ? IDX_W'(rem_diff - arpc_pkg::REM_DIV)
                                               : IDX_W'(rem_diff);
      end
      rem_phase <= 1'b1;
    end
  end

  logic [IDX_W-1:0] idx;
  assign idx = arpc_pkg::IDX_IS_POW2 ? ip_q[IDX_W-1:0] : rem;

  // Clearing sweep address
  logic [IDX_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Entry memory: {valid, ip tag, mac}
  logic [arpc_pkg::ENTRY_W-1:0] mem [arpc_pkg::CACHE_ENTRIES];
  logic [arpc_pkg::ENTRY_W-1:0] rd_q;
  logic                         wr_en;
  logic [IDX_W-1:0]             wr_addr;
  logic [arpc_pkg::ENTRY_W-1:0] wr_data;

  assign wr_en   = cmd.clr_step || cmd.mem_wr;
  assign wr_addr = cmd.clr_step ? clr_addr : idx;
  assign wr_data = cmd.clr_step ? '0 : {1'b1, ip_q, mac_q};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      rd_q <= mem[idx];
    end
  end

  logic                        rd_valid;
  logic [arpc_pkg::IP_W-1:0]   rd_ip;
  logic [arpc_pkg::MAC_W-1:0]  rd_mac;
  assign {rd_valid, rd_ip, rd_mac} = rd_q;

  // Configuration registers
  logic [arpc_pkg::MAC_W-1:0]  gw_mac;
  logic [arpc_pkg::TICK_W-1:0] retry;

  always_ff @(posedge clk) begin
    if (rst) begin
      gw_mac <= arpc_pkg::GW_MAC_RESET;
      retry  <= arpc_pkg::RETRY_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        arpc_pkg::REG_GW_MAC: gw_mac <= cfg_wdata;
        arpc_pkg::REG_RETRY:  retry  <= cfg_wdata[arpc_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Lookup result and request pacing
  logic [arpc_pkg::TICK_W-1:0] ticks;
  logic                        tag_hit;
  logic                        arp_due;

  assign tag_hit = rd_valid && (rd_ip == ip_q);
  assign arp_due = !tag_hit && (ticks > retry);

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks <= '1;
    end else if (cmd.resolve && arp_due) begin
      ticks <= '0;
    end else if (cmd.tick && (ticks != '1)) begin
      ticks <= ticks + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.resolve) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resolve) begin
      hit      <= tag_hit;
      hop_mac  <= tag_hit ? rd_mac : gw_mac;
      send_arp <= arp_due;
    end
  end

  // Status to controller
  assign sts.func     = func_q;
  assign sts.clr_last = (clr_addr == arpc_pkg::LAST_IDX);
  assign sts.rem_last = rem_phase;
  assign sts.out_free = !out_valid || out_ready;

  // A result is never loaded over one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.resolve |-> (!out_valid || out_ready))
    else $error("output register overwritten");

  // Raising the request flag restarts the elapsed count
  a_flag_restarts: assert property (@(posedge clk) disable iff (rst)
    (cmd.resolve && arp_due) |=> (ticks == '0) && send_arp && !hit)
    else $error("request flag did not restart elapsed count");

  // Reads and writes of the entry memory never coincide
  a_rd_wr_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.mem_rd && wr_en))
    else $error("entry read and write in the same cycle");

endmodule

`default_nettype wire

>>> hw/rtl/direct_mapped_arp_cache.sv
// Direct-mapped IPv4-to-MAC cache. An add or a tick is latched, then executed, before the next
// request is accepted; a resolve is latched, reads its entry, then waits on out_ready to load
// the registered result. With a non-power-of-two entry count the index remainder runs
// between latch and execute (reciprocal multiply, then one correction).
// Reset is synchronous; afterwards a sweep over all CACHE_ENTRIES entries clears the
// valid bits, during which in_ready is low; config writes are taken throughout.
`default_nettype none

module direct_mapped_arp_cache (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [arpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [arpc_pkg::MAC_W-1:0]      cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [arpc_pkg::FUNC_W-1:0]     func,
  input  wire logic [arpc_pkg::IP_W-1:0]       ip_addr,
  input  wire logic [arpc_pkg::MAC_W-1:0]      mac_in,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 hit,
  output logic [arpc_pkg::MAC_W-1:0]           hop_mac,
  output logic                                 send_arp
);

  arpc_pkg::cmd_t cmd;
  arpc_pkg::sts_t sts;

  arpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  arpc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .func         (func),
    .ip_addr      (ip_addr),
    .mac_in       (mac_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hit          (hit),
    .hop_mac      (hop_mac),
    .send_arp     (send_arp)
  );

endmodule

`default_nettype wire

>>> test/tb_direct_mapped_arp_cache.sv
// Testbench for direct_mapped_arp_cache: directed and random add/resolve/tick
// requests checked against a behavioral cache predictor. Depends on arpc_pkg.
`timescale 1ns / 100ps

module tb_direct_mapped_arp_cache;

  localparam logic [arpc_pkg::FUNC_W-1:0] FUNC_NOP = 2'd3;  // unused code, ignored
  localparam int SLOTS = arpc_pkg::CACHE_ENTRIES;
  localparam int SETTLE_CYCLES = 40;              // covers add/tick latency incl. remainder

  typedef struct packed {
    logic [arpc_pkg::FUNC_W-1:0] func;
    logic [arpc_pkg::IP_W-1:0]   ip;
    logic [arpc_pkg::MAC_W-1:0]  mac;
  } arp_req_t;

  typedef struct packed {
    logic                       hit;
    logic [arpc_pkg::MAC_W-1:0] mac;
    logic                       arp;
  } next_hop_t;

  // DUT signals; the driven inputs are known from time zero
  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_wr_en = 1'b0;
  logic [arpc_pkg::CFG_IDX_W-1:0] cfg_index = arpc_pkg::REG_GW_MAC;
  logic [arpc_pkg::MAC_W-1:0]     cfg_wdata = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [arpc_pkg::FUNC_W-1:0]    func = arpc_pkg::FUNC_TICK;
  logic [arpc_pkg::IP_W-1:0]      ip_addr = '0;
  logic [arpc_pkg::MAC_W-1:0]     mac_in = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic                           hit;
  logic [arpc_pkg::MAC_W-1:0]     hop_mac;
  logic                           send_arp;

  direct_mapped_arp_cache dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .ip_addr      (ip_addr),
    .mac_in       (mac_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hit          (hit),
    .hop_mac      (hop_mac),
    .send_arp     (send_arp)
  );

  always #6 clk = ~clk;

  // Predicted cache state and registers
  logic [arpc_pkg::IP_W-1:0]   cached_ip    [SLOTS];
  logic [arpc_pkg::MAC_W-1:0]  cached_mac   [SLOTS];
  logic                        cached_valid [SLOTS];
  logic [arpc_pkg::TICK_W-1:0] elapsed_ticks;
  logic [arpc_pkg::MAC_W-1:0]  gw_mac;
  logic [arpc_pkg::TICK_W-1:0] retry_ticks;

  arp_req_t  pending_reqs[$];
  next_hop_t expected_hops[$];
  int        errors = 0;
  bit        quiet = 1'b0;       // no idling on either side
  int        send_gap_pct = 0;
  int        recv_gap_pct = 0;
  int        send_gap = 0;
  int        recv_gap = 0;

  initial begin
    for (int i = 0; i < SLOTS; i++) cached_valid[i] = 1'b0;
    elapsed_ticks = '1;
    gw_mac = arpc_pkg::GW_MAC_RESET;
    retry_ticks = arpc_pkg::RETRY_RESET;
  end

  // Apply one accepted request to the predicted cache
  task automatic cache_apply(input arp_req_t r);
    int unsigned slot;
    next_hop_t   res;
    slot = r.ip % SLOTS;
    case (r.func)
      arpc_pkg::FUNC_ADD: begin
        cached_ip[slot] = r.ip;
        cached_mac[slot] = r.mac;
        cached_valid[slot] = 1'b1;
      end
      arpc_pkg::FUNC_RESOLVE: begin
        if (cached_valid[slot] && cached_ip[slot] == r.ip) begin
          res = '{hit: 1'b1, mac: cached_mac[slot], arp: 1'b0};
        end else begin
          res = '{hit: 1'b0, mac: gw_mac, arp: 1'b0};
          if (elapsed_ticks > retry_ticks) begin
            elapsed_ticks = '0;
            res.arp = 1'b1;
          end
        end
        expected_hops.push_back(res);
      end
      arpc_pkg::FUNC_TICK: begin
        if (elapsed_ticks != '1) elapsed_ticks = elapsed_ticks + 1'b1;
      end
      default: ;
    endcase
  endtask

  // Request driver
  always @(posedge clk) begin : drive
    arp_req_t req;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) cache_apply('{func: func, ip: ip_addr, mac: mac_in});
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(99) < send_gap_pct) begin
        send_gap <= $urandom_range(8);
        in_valid <= 1'b0;
      end else begin
        req = pending_reqs.pop_front();
        in_valid <= 1'b1;
        func <= req.func;
        ip_addr <= req.ip;
        mac_in <= req.mac;
      end
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk) begin : observe
    next_hop_t want;
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_hops.size() == 0) begin
          $error("unexpected result: hit %0d hop_mac %h send_arp %0d",
                 hit, hop_mac, send_arp);
          errors++;
        end else begin
          want = expected_hops.pop_front();
          if (hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, hit);
            errors++;
          end
          if (hop_mac !== want.mac) begin
            $error("hop_mac: expected %h, got %h", want.mac, hop_mac);
            errors++;
          end
          if (send_arp !== want.arp) begin
            $error("send_arp: expected %0d, got %0d", want.arp, send_arp);
            errors++;
          end
        end
      end
      if (recv_gap != 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(99) < recv_gap_pct) begin
        recv_gap <= $urandom_range(8);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic queue_req(input logic [arpc_pkg::FUNC_W-1:0] f,
                           input logic [arpc_pkg::IP_W-1:0] ip,
                           input logic [arpc_pkg::MAC_W-1:0] mac);
    pending_reqs.push_back('{func: f, ip: ip, mac: mac});
  endtask

  // Hold off until every request is sent and every lookup answered
  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid || expected_hops.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both registers, written back to back while idle
  task automatic set_config(input logic [arpc_pkg::MAC_W-1:0] gw,
                            input logic [arpc_pkg::TICK_W-1:0] retry);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= arpc_pkg::REG_GW_MAC;
    cfg_wdata <= gw;
    @(posedge clk);
    gw_mac = gw;
    cfg_index <= arpc_pkg::REG_RETRY;
    cfg_wdata <= arpc_pkg::MAC_W'(retry);
    @(posedge clk);
    retry_ticks = retry;
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [arpc_pkg::MAC_W-1:0] rand_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Stimulus
  initial begin : stimulus
    logic [arpc_pkg::IP_W-1:0]   addr_pool[32];
    logic [arpc_pkg::IP_W-1:0]   addr;
    logic [arpc_pkg::FUNC_W-1:0] f;
    int                          sent;
    int                          pick;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset values: saturated counter, first miss requests, replacement, unused code
    queue_req(arpc_pkg::FUNC_TICK, 32'h0, 48'h0);
    queue_req(arpc_pkg::FUNC_RESOLVE, 32'h0000_0000, 48'h0);
    queue_req(arpc_pkg::FUNC_RESOLVE, 32'hFFFF_FFFF, rand_mac());
    queue_req(arpc_pkg::FUNC_ADD, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    queue_req(arpc_pkg::FUNC_RESOLVE, 32'hFFFF_FFFF, 48'h0);
    queue_req(arpc_pkg::FUNC_ADD, 32'h0000_0000, 48'h0);
    queue_req(arpc_pkg::FUNC_RESOLVE, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
    queue_req(arpc_pkg::FUNC_RESOLVE, 32'h0000_0080, 48'h0);
    queue_req(arpc_pkg::FUNC_ADD, 32'h0000_0080, 48'h1234_5678_9ABC);
    queue_req(arpc_pkg::FUNC_RESOLVE, 32'h0000_0000, 48'h0);
    queue_req(arpc_pkg::FUNC_RESOLVE, 32'h0000_0080, 48'h0);
    queue_req(FUNC_NOP, 32'h0000_0080, 48'hFFFF_FFFF_FFFF);
    queue_req(arpc_pkg::FUNC_RESOLVE, 32'h0000_0080, 48'h0);
    drain();

    // Zero retry interval: one tick is enough for the next request flag
    set_config(48'h0, 32'h0);
    queue_req(arpc_pkg::FUNC_TICK, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    queue_req(arpc_pkg::FUNC_RESOLVE, 32'h1234_5601, 48'h0);
    queue_req(arpc_pkg::FUNC_RESOLVE, 32'h1234_5601, 48'h0);
    queue_req(arpc_pkg::FUNC_TICK, 32'h0, 48'h0);
    queue_req(arpc_pkg::FUNC_RESOLVE, 32'hA5A5_5A5A, 48'h0);
    drain();

    // Largest retry interval: the flag can never be raised
    set_config(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    queue_req(arpc_pkg::FUNC_TICK, 32'h0, 48'h0);
    queue_req(arpc_pkg::FUNC_TICK, 32'h0, 48'h0);
    queue_req(arpc_pkg::FUNC_RESOLVE, 32'h7654_3210, 48'h0);
    drain();

    // Random phases; small address pool with colliding slots for hits and replacements
    for (int i = 0; i < 32; i++) begin
      addr = $urandom();
      addr_pool[i] = (addr & ~32'h7F) | $urandom_range(19);
    end
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_config(rand_mac(), 32'h0);
        3: set_config(rand_mac(), $urandom());
        default: set_config(rand_mac(), $urandom_range(15));
      endcase
      pick = $urandom_range(2);
      send_gap_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 40;
      pick = $urandom_range(2);
      recv_gap_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 40;
      quiet = (phase == 5);
      sent = 0;
      while (sent < 190) begin
        pick = $urandom_range(99);
        if (pick < 30) f = arpc_pkg::FUNC_ADD;
        else if (pick < 75) f = arpc_pkg::FUNC_RESOLVE;
        else if (pick < 97) f = arpc_pkg::FUNC_TICK;
        else f = FUNC_NOP;
        addr = ($urandom_range(3) == 0) ? $urandom() : addr_pool[$urandom_range(31)];
        queue_req(f, addr, rand_mac());
        if (f != FUNC_NOP) sent++;
      end
      drain();
    end

    if (errors == 0) begin
      $display("direct_mapped_arp_cache: match");
    end else begin
      $display("direct_mapped_arp_cache: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("direct_mapped_arp_cache: mismatch");
    $finish;
  end

endmodule
